/* design/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] hash_t;

	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;
	localparam logic [7:0] PAD_BYTE    = 8'h80;

	typedef struct packed {
		logic pad;
		logic tail;
		logic len;
	} pad_ctrl_t;

	typedef struct packed {
		logic       load;
		logic       run;
		logic [5:0] rnd;
	} core_ctrl_t;

	function automatic word_t iv_word(input logic [2:0] i);
		word_t r;
		case (i)
			3'd0:    r = 32'h6a09e667;
			3'd1:    r = 32'hbb67ae85;
			3'd2:    r = 32'h3c6ef372;
			3'd3:    r = 32'ha54ff53a;
			3'd4:    r = 32'h510e527f;
			3'd5:    r = 32'h9b05688c;
			3'd6:    r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic word_t k_const(input logic [5:0] t);
		word_t r;
		case (t)
			6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
			6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
			6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
			6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
			6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t sml_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t sml_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

/* design/sha_wbuf.sv */
// ----------------------------------------------------------------------------
// sha_wbuf
// Block buffer: packs bytes into big-endian words, holds 16 words in a
// synchronous RAM and returns padded schedule words on read.
// ----------------------------------------------------------------------------
module sha_wbuf (
	input  logic               clk,
	input  logic               byte_we,
	input  logic [7:0]         byte_in,
	input  logic [5:0]         fill,
	input  logic [3:0]         rd_addr,
	input  sha_pkg::pad_ctrl_t pad,
	input  logic [63:0]        bits,
	output sha_pkg::word_t     word
);
	import sha_pkg::*;

	word_t      mem_q [16];
	word_t      rdata_s1;
	logic [3:0] addr_s1;
	logic [23:0] acc_q;

	always_ff @(posedge clk) begin
		if (byte_we) begin
			acc_q <= {acc_q[15:0], byte_in};
			if (fill[1:0] == 2'd3) begin
				mem_q[fill[5:2]] <= {acc_q, byte_in};
			end
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem_q[rd_addr];
		addr_s1  <= rd_addr;
	end

	// partial word gets the 0x80 marker after the bytes already held
	always_comb begin
		word = rdata_s1;
		if (pad.pad) begin
			if (pad.tail || addr_s1 > fill[5:2]) begin
				word = '0;
			end else if (addr_s1 == fill[5:2]) begin
				case (fill[1:0])
					2'd0:    word = {PAD_BYTE, 24'd0};
					2'd1:    word = {acc_q[7:0], PAD_BYTE, 16'd0};
					2'd2:    word = {acc_q[15:0], PAD_BYTE, 8'd0};
					default: word = {acc_q, PAD_BYTE};
				endcase
			end
			if (pad.len && addr_s1 == LEN_HI_WORD) begin
				word = bits[63:32];
			end
			if (pad.len && addr_s1 == LEN_LO_WORD) begin
				word = bits[31:0];
			end
		end
	end

endmodule

/* design/sha_core.sv */
// ----------------------------------------------------------------------------
// sha_core
// One SHA-256 round per cycle while run is set; rolling 16-word schedule.
// ----------------------------------------------------------------------------
module sha_core (
	input  logic                clk,
	input  sha_pkg::core_ctrl_t ctrl,
	input  sha_pkg::hash_t      chain,
	input  sha_pkg::word_t      w_in,
	output sha_pkg::hash_t      vars
);
	import sha_pkg::*;

	hash_t v_q;
	word_t w_q [16];
	word_t w_calc;
	word_t wt;
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	assign w_calc = w_q[0] + sml_sigma0(w_q[1]) + w_q[9] + sml_sigma1(w_q[14]);
	assign wt     = (ctrl.rnd[5:4] == 2'd0) ? w_in : w_calc;
	assign ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1     = v_q[7] + big_sigma1(v_q[4]) + ch + k_const(ctrl.rnd) + wt;
	assign t2     = big_sigma0(v_q[0]) + maj;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= chain;
		end else if (ctrl.run) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wt;
		end
	end

	assign vars = v_q;

endmodule

/* design/sha256_message_hasher_unit.sv */
// ----------------------------------------------------------------------------
// sha256_message_hasher_unit
// Streaming SHA-256: bytes in, padded and compressed, digest words out.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata               | tuser         | tlast
//  s_axis   | in  | [7:0] data byte     | [0] byte flag | end of message
//  m_axis   | out | [31:0] digest word  | [2:0] index   | last digest word
//
//  A full block is loaded, run through 64 rounds in the round unit and folded
//  into the chain value; end of message adds one or two padding blocks and
//  eight output beats. After reset the chain value holds the initial hash,
//  length and fill zero. s_axis_tready is low while a block compresses or
//  the digest drains; a stalled output beat holds.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] byte_valid
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,  // [2:0] word_index
	output logic        m_axis_tlast
);
	import sha_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_LOAD  = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FOLD  = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		BLK_DATA = 3'b001,
		BLK_PADA = 3'b010,
		BLK_PADB = 3'b100
	} blk_t;

	state_t      state_q;
	blk_t        kind_q;
	logic        end_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	hash_t       chain_q;
	hash_t       vars;
	word_t       w_word;
	logic [3:0]  rd_addr;
	pad_ctrl_t   pad;
	core_ctrl_t  cctl;
	logic        in_beat;
	logic        out_beat;
	logic        byte_we;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign byte_we       = in_beat && s_axis_tuser[0];
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_beat      = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = chain_q[0];
	assign m_axis_tuser  = idx_q;
	assign m_axis_tlast  = (idx_q == 3'd7);

	assign rd_addr = (state_q == ST_LOAD) ? 4'd0 : rnd_q[3:0] + 4'd1;

	assign pad.pad  = (kind_q != BLK_DATA);
	assign pad.tail = (kind_q == BLK_PADB);
	assign pad.len  = (kind_q == BLK_PADB) || (fill_q[5:3] != 3'd7);

	assign cctl.load = (state_q == ST_LOAD);
	assign cctl.run  = (state_q == ST_ROUND);
	assign cctl.rnd  = rnd_q;

	sha_wbuf u_wbuf (
		.clk     (clk),
		.byte_we (byte_we),
		.byte_in (s_axis_tdata),
		.fill    (fill_q),
		.rd_addr (rd_addr),
		.pad     (pad),
		.bits    (bits_q),
		.word    (w_word)
	);

	sha_core u_core (
		.clk   (clk),
		.ctrl  (cctl),
		.chain (chain_q),
		.w_in  (w_word),
		.vars  (vars)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= BLK_DATA;
			end_q   <= 1'b0;
			fill_q  <= '0;
			bits_q  <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= iv_word(3'(i));
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if (s_axis_tuser[0]) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						end_q <= s_axis_tlast;
						if (s_axis_tuser[0] && fill_q == 6'd63) begin
							kind_q  <= BLK_DATA;
							state_q <= ST_LOAD;
						end else if (s_axis_tlast) begin
							kind_q  <= BLK_PADA;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + vars[i];
					end
					unique case (kind_q)
						BLK_DATA: begin
							if (end_q) begin
								kind_q  <= BLK_PADA;
								state_q <= ST_LOAD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						BLK_PADA: begin
							if (fill_q[5:3] == 3'd7) begin
								kind_q  <= BLK_PADB;
								state_q <= ST_LOAD;
							end else begin
								idx_q   <= '0;
								state_q <= ST_OUT;
							end
						end
						default: begin
							idx_q   <= '0;
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (out_beat) begin
						// shift the digest out, refill with the initial value
						for (int i = 0; i < 7; i++) begin
							chain_q[i] <= chain_q[i + 1];
						end
						chain_q[7] <= iv_word(idx_q);
						idx_q      <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							fill_q  <= '0;
							bits_q  <= '0;
							end_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input and output active together");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
		else $error("round count overrun");

	a_chain_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_beat && m_axis_tlast) |=> (chain_q[0] == iv_word(3'd0) && fill_q == 6'd0
			&& bits_q == 64'd0))
		else $error("chain not restored after digest");

	a_pad_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (kind_q != BLK_DATA))
		else $error("digest after data block");

endmodule

/* sim/sha256_digest_checker.sv */
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both streams of the SHA-256 hasher. It keeps its own hash state,
// computes the digest words due for each message that ends, and compares
// every output beat in order against them.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] byte_valid
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // [31:0] digest_word
	input  logic [2:0]  m_axis_tuser,  // [2:0] word_index
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending,
	output int          words_checked
);

	typedef struct packed {
		sha_pkg::word_t word;
		logic [2:0]     idx;
		logic           last;
	} digest_beat_t;

	sha_pkg::word_t round_k [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	sha_pkg::word_t init_hash [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	sha_pkg::word_t chain_h [0:7];
	logic [7:0]     blk_bytes [0:63];
	int unsigned    fill_cnt;
	logic [63:0]    msg_bit_len;
	digest_beat_t   digest_q [$];
	digest_beat_t   want_beat;
	int             err_total;
	int             words_total;

	assign fail_count    = err_total;
	assign words_checked = words_total;

	function automatic sha_pkg::word_t ror(input sha_pkg::word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void sha_compress();
		sha_pkg::word_t sched [0:63];
		sha_pkg::word_t a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			sched[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
			s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
			sched[i] = sched[i-16] + s0 + sched[i-7] + s1;
		end
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ round_k[i] + sched[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endfunction

	function automatic void start_message();
		for (int i = 0; i < 8; i++)
			chain_h[i] = init_hash[i];
		fill_cnt    = 0;
		msg_bit_len = '0;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		blk_bytes[fill_cnt] = b;
		fill_cnt++;
		msg_bit_len += 64'd8;
		if (fill_cnt == 64) begin
			sha_compress();
			fill_cnt = 0;
		end
	endfunction

	// pad, fold in the length, queue the eight digest beats
	function automatic void finish_message();
		digest_beat_t beat;
		blk_bytes[fill_cnt] = sha_pkg::PAD_BYTE;
		for (int i = fill_cnt + 1; i < 64; i++)
			blk_bytes[i] = 8'h00;
		if (fill_cnt >= 56) begin
			sha_compress();
			for (int i = 0; i < 64; i++)
				blk_bytes[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			blk_bytes[63 - i] = msg_bit_len[8*i +: 8];
		sha_compress();
		for (int i = 0; i < 8; i++) begin
			beat.word = chain_h[i];
			beat.idx  = 3'(i);
			beat.last = (i == 7);
			digest_q.push_back(beat);
		end
		start_message();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_message();
			for (int i = 0; i < 64; i++)
				blk_bytes[i] = 8'h00;
			digest_q.delete();
			err_total   = 0;
			words_total = 0;
			pending     <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0])
					absorb_byte(s_axis_tdata);
				if (s_axis_tlast)
					finish_message();
			end
			if (m_axis_tvalid && m_axis_tready) begin
				words_total++;
				if (digest_q.size() == 0) begin
					err_total++;
					if (err_total <= 10)
						$display("unexpected digest beat: word %h idx %0d last %b",
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want_beat = digest_q.pop_front();
					if (m_axis_tdata !== want_beat.word || m_axis_tuser !== want_beat.idx
							|| m_axis_tlast !== want_beat.last) begin
						err_total++;
						if (err_total <= 10)
							$display("digest mismatch: exp %h/%0d/%b, got %h/%0d/%b",
								want_beat.word, want_beat.idx, want_beat.last,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
			pending <= digest_q.size();
		end
	end

endmodule

/* sim/tb_sha256_message_hasher_unit.sv */
// ----------------------------------------------------------------------------
// tb_sha256_message_hasher_unit
// Feeds byte streams to the SHA-256 hasher: a few directed messages (empty,
// single bytes, end with and without a byte, ignored beats), then random
// messages, some at the padding boundaries, with random gaps and back-pressure.
// The checker beside the block predicts and compares every digest beat.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TOTAL_ITEMS    = 410;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic [0:0]  s_axis_tuser;   // [0] byte_valid
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] digest_word
	logic [2:0]  m_axis_tuser;   // [2:0] word_index
	logic        m_axis_tlast;

	int fail_count;
	int pending;
	int words_checked;
	int stall_cycles;
	int items_sent;
	int msgs_sent;
	int bytes_sent;
	int longest_msg;
	bit tx_burst;

	sha256_message_hasher_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	sha256_digest_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 10);
		else
			return $urandom_range(15, 40);
	endfunction

	// called and returns at a falling edge
	task automatic send_beat(input logic [7:0] d, input logic has_byte, input logic eom);
		int unsigned gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= has_byte;
		s_axis_tlast  <= eom;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_message(input int len, input bit end_on_byte, input bit noisy);
		for (int i = 0; i < len; i++) begin
			if (noisy && $urandom_range(0, 24) == 0) begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
				items_sent++;
			end
			send_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
		end
		if (!end_on_byte || len == 0) begin
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
			items_sent++;
		end
		items_sent += len;
		bytes_sent += len;
		msgs_sent++;
		if (len > longest_msg)
			longest_msg = len;
	endtask

	function automatic int pick_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, 12);
		else if (r < 80)
			return $urandom_range(13, 50);
		case ($urandom_range(0, 7))
			0:       return 55;
			1:       return 56;
			2:       return 57;
			3:       return 63;
			4:       return 64;
			5:       return 65;
			6:       return 119;
			default: return 120;
		endcase
	endfunction

	// output back-pressure: runs of ready, short and long stalls
	initial begin
		int unsigned hold;
		bit          rdy;
		hold = 0;
		rdy  = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				if (!rdy) begin
					rdy  = 1'b1;
					hold = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
						: $urandom_range(1, 12);
				end else begin
					hold = pick_gap();
					rdy  = (hold == 0);
					if (hold == 0)
						hold = 1;
				end
			end
			m_axis_tready <= rdy;
			hold--;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		items_sent    = 0;
		msgs_sent     = 0;
		bytes_sent    = 0;
		longest_msg   = 0;
		tx_burst      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message, then an ignored beat
		send_beat(8'h5a, 1'b0, 1'b1);
		send_beat(8'ha5, 1'b0, 1'b0);
		// "abc" with end on the last byte
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		// extreme bytes, end beat carries no byte
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'hff, 1'b0, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h00, 1'b0, 1'b1);
		items_sent += 12;
		msgs_sent  += 6;
		bytes_sent += 7;
		longest_msg = 3;

		while (items_sent < TOTAL_ITEMS) begin
			int len;
			bit end_on_byte;
			len = pick_length();
			if (len > TOTAL_ITEMS - items_sent)
				len = TOTAL_ITEMS - items_sent;
			end_on_byte = (len != 0) && $urandom_range(0, 1);
			tx_burst    = ($urandom_range(0, 3) == 0);
			send_message(len, end_on_byte, !tx_burst);
		end
		tx_burst = 1'b0;

		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);

		$display("Hashed %0d messages, %0d bytes in all, longest %0d bytes;",
			msgs_sent, bytes_sent, longest_msg);
		$display("checked %0d digest words under random gaps and back-pressure.", words_checked);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
design/sha_pkg.sv
design/sha_wbuf.sv
design/sha_core.sv
design/sha256_message_hasher_unit.sv
sim/sha256_digest_checker.sv
sim/tb_sha256_message_hasher_unit.sv
